// ===== src/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 width decoder.
// No dependencies.
`default_nettype none

package u8dec_pkg;

    localparam int ACCUM_BITS = 31;
    localparam int LEFT_BITS  = 3;
    localparam int CODE_BITS  = 16;
    localparam int CW_BITS    = 2;

    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD5_MIN = 8'hF8;
    localparam logic [7:0] LEAD6_MIN = 8'hFC;

    localparam logic [7:0] MASK1 = 8'h7F;
    localparam logic [7:0] MASK2 = 8'h1F;
    localparam logic [7:0] MASK3 = 8'h0F;
    localparam logic [7:0] MASK4 = 8'h07;
    localparam logic [7:0] MASK5 = 8'h03;
    localparam logic [7:0] MASK6 = 8'h01;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    localparam logic [CODE_BITS-1:0] REPL_CODE  = 16'h25A1;
    localparam logic [CODE_BITS-1:0] NARROW_LO  = 16'h0100;
    localparam logic [CODE_BITS-1:0] NARROW_HI  = 16'hFF20;
    localparam logic [CODE_BITS-1:0] TOTAL_MAX  = 16'hFFFF;

    localparam logic [CW_BITS-1:0] CW_NONE   = 2'd0;
    localparam logic [CW_BITS-1:0] CW_NARROW = 2'd1;
    localparam logic [CW_BITS-1:0] CW_WIDE   = 2'd2;

    typedef struct packed {
        logic [CODE_BITS-1:0] code_unit;
        logic [CW_BITS-1:0]   char_width;
        logic                 was_replaced;
        logic                 end_of_string;
    } u8dec_result_t;

endpackage

`default_nettype wire

// ===== src/u8dec_core.sv =====
// Per-byte decode step: lead classification, continuation append, finish.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_core
    import u8dec_pkg::*;
(
    input  wire logic [7:0]            byte_in,
    input  wire logic [ACCUM_BITS-1:0] accum,
    input  wire logic [LEFT_BITS-1:0]  left,
    output logic      [ACCUM_BITS-1:0] accum_next,
    output logic      [LEFT_BITS-1:0]  left_next,
    output logic                       emit,
    output u8dec_result_t              result
);

    logic [ACCUM_BITS-1:0] acc_new;
    logic [LEFT_BITS-1:0]  left_new;
    logic [7:0]            mask;
    logic [CODE_BITS-1:0]  code;
    logic                  repl;

    always_comb
    begin
        mask     = MASK1;
        left_new = '0;
        acc_new  = '0;
        if (left == '0)
        begin
            priority if (byte_in < LEAD2_MIN)
            begin
                mask = MASK1; left_new = 3'd0;
            end
            else if (byte_in < LEAD3_MIN)
            begin
                mask = MASK2; left_new = 3'd1;
            end
            else if (byte_in < LEAD4_MIN)
            begin
                mask = MASK3; left_new = 3'd2;
            end
            else if (byte_in < LEAD5_MIN)
            begin
                mask = MASK4; left_new = 3'd3;
            end
            else if (byte_in < LEAD6_MIN)
            begin
                mask = MASK5; left_new = 3'd4;
            end
            else
            begin
                mask = MASK6; left_new = 3'd5;
            end
            acc_new = {{(ACCUM_BITS-8){1'b0}}, byte_in & mask};
        end
        else
        begin
            acc_new  = {accum[ACCUM_BITS-7:0], byte_in[5:0] & CONT_MASK[5:0]};
            left_new = left - 3'd1;
        end
    end

    // finished character
    assign repl = |acc_new[ACCUM_BITS-1:CODE_BITS];
    assign code = repl ? REPL_CODE : acc_new[CODE_BITS-1:0];

    always_comb
    begin
        result = '0;
        if (byte_in == 8'd0)
        begin
            emit                 = 1'b1;
            accum_next           = '0;
            left_next            = '0;
            result.end_of_string = 1'b1;
            result.char_width    = CW_NONE;
        end
        else if (left_new == '0)
        begin
            emit                = 1'b1;
            accum_next          = '0;
            left_next           = '0;
            result.code_unit    = code;
            result.was_replaced = repl;
            result.char_width   = (code < NARROW_LO || code > NARROW_HI) ? CW_NARROW : CW_WIDE;
        end
        else
        begin
            emit       = 1'b0;
            accum_next = acc_new;
            left_next  = left_new;
        end
    end

endmodule

`default_nettype wire

// ===== src/utf8_to_ucs2_width_decoder.sv =====
// UTF-8 to UCS-2 decoder with display width and running width total.
// Depends on u8dec_pkg and u8dec_core.
//
// Accepts one UTF-8 byte per cycle on a valid/ready request channel. Each byte is
// captured in an input register, decoded by a single combinational step and the
// result, if any, lands in an output register; a stalled output holds the byte in
// the input register, and the block sustains one byte per clock whenever the
// output is taken. Lead bytes emit nothing until the final continuation byte.
// A zero byte ends the string: it emits the total with end_of_string set and clears
// all state, including a partial character. width_total saturates at 0xFFFF; the
// internal sum is WIDTH_COUNT_BITS wide and saturates at its own maximum.
`default_nettype none

module utf8_to_ucs2_width_decoder
    import u8dec_pkg::*;
#(
    parameter int WIDTH_COUNT_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [CODE_BITS-1:0] code_unit,
    output logic      [CW_BITS-1:0]   char_width,
    output logic                      was_replaced,
    output logic      [15:0]          width_total,
    output logic                      end_of_string
);

    localparam int W = WIDTH_COUNT_BITS;

    logic [7:0]            byte_reg;
    logic                  byte_valid_reg;
    logic [ACCUM_BITS-1:0] accum_reg, accum_next;
    logic [LEFT_BITS-1:0]  left_reg, left_next;
    logic [W-1:0]          sum_reg, sum_next;
    logic                  out_valid_reg;
    u8dec_result_t         res_reg, res_next;
    logic [15:0]           total_reg, total_next;

    logic                  emit;
    logic                  out_free;
    logic                  advance;
    logic [W:0]            sum_inc;
    logic [W-1:0]          sum_sat;
    logic [W-1:0]          total_src;

    u8dec_core u_core (
        .byte_in    (byte_reg),
        .accum      (accum_reg),
        .left       (left_reg),
        .accum_next (accum_next),
        .left_next  (left_next),
        .emit       (emit),
        .result     (res_next)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = byte_valid_reg && (!emit || out_free);
    assign in_ready = !byte_valid_reg || advance;

    assign sum_inc   = {1'b0, sum_reg} + {{(W+1-CW_BITS){1'b0}}, res_next.char_width};
    assign sum_sat   = sum_inc[W] ? {W{1'b1}} : sum_inc[W-1:0];
    assign total_src = res_next.end_of_string ? sum_reg : sum_sat;
    assign sum_next  = res_next.end_of_string ? '0 : (emit ? sum_sat : sum_reg);

    generate
        if (W > 16)
        begin : g_wide
            assign total_next = (|total_src[W-1:16]) ? TOTAL_MAX : total_src[15:0];
        end
        else if (W == 16)
        begin : g_exact
            assign total_next = total_src;
        end
        else
        begin : g_narrow
            assign total_next = {{(16-W){1'b0}}, total_src};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            accum_reg      <= '0;
            left_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                byte_valid_reg <= in_valid;
            if (advance)
            begin
                accum_reg <= accum_next;
                left_reg  <= left_next;
                sum_reg   <= sum_next;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= in_byte;
        if (advance && emit)
        begin
            res_reg   <= res_next;
            total_reg <= total_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign code_unit     = res_reg.code_unit;
    assign char_width    = res_reg.char_width;
    assign was_replaced  = res_reg.was_replaced;
    assign end_of_string = res_reg.end_of_string;
    assign width_total   = total_reg;

endmodule

`default_nettype wire
